@@ hw/rtl/sars_pkg.sv @@
// Shared types and constants for the serial converter read sequencer.
// No dependencies; imported by every module of the block.
package sars_pkg;

  localparam int unsigned HALF_PERIOD_W     = 16;
  localparam int unsigned SLOT_W            = 6;
  localparam int unsigned WORD_W            = 8;
  localparam int unsigned IN_TDATA_W        = 8;
  localparam int unsigned OUT_TDATA_W       = 16;

  localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RESET = 16'd100;

  // slot map of one read
  localparam logic [SLOT_W-1:0] SETUP_SLOTS    = 6'd7;   // start, single-ended, channel bits
  localparam logic [SLOT_W-1:0] DATA_MSB_FIRST = 6'd8;   // first MSB-first sample slot
  localparam logic [SLOT_W-1:0] DATA_MSB_LAST  = 6'd22;  // last MSB sample, also LSB word bit 0
  localparam logic [SLOT_W-1:0] DATA_LSB_FIRST = 6'd24;
  localparam logic [SLOT_W-1:0] DATA_LSB_LAST  = 6'd36;
  localparam logic [SLOT_W-1:0] LAST_SLOT      = 6'd38;
  localparam logic [SLOT_W-1:0] SETUP_LOW_DATA = 6'd4;   // single-ended bit is driven low

  typedef struct packed {
    logic cs;
    logic clk;
    logic dout;
    logic drv;
  } pins_t;

  localparam pins_t PINS_RESET    = '{cs: 1'b1, clk: 1'b0, dout: 1'b0, drv: 1'b0};
  localparam pins_t PINS_FINISHED = '{cs: 1'b1, clk: 1'b0, dout: 1'b1, drv: 1'b1};

  // one result item
  typedef struct packed {
    pins_t             pins;
    logic              done;
    logic [WORD_W-1:0] value;
    logic              match;
  } res_t;

endpackage

@@ hw/rtl/sars_seq.sv @@
// Slot sequencer: half-period tick counter, slot index, pin levels and the
// two sample words. Advances once per accepted item. Depends on sars_pkg.
module sars_seq
  import sars_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [HALF_PERIOD_W-1:0] cfg_wr_data,
  input  logic                     step,
  input  logic                     start_req,
  input  logic                     data_in,
  output res_t                     res
);

  logic [HALF_PERIOD_W-1:0] half_period;
  logic                     busy, busy_next;
  logic [SLOT_W-1:0]        slot_index, slot_index_next;
  logic [HALF_PERIOD_W-1:0] tick_counter, tick_counter_next;
  logic [WORD_W-1:0]        first_word, first_word_next;
  logic [WORD_W-1:0]        second_word, second_word_next;
  pins_t                    pin_levels, pin_levels_next;

  logic [HALF_PERIOD_W-1:0] hp_eff;
  logic [HALF_PERIOD_W-1:0] tick_inc;
  logic                     slot_end;
  logic [SLOT_W-1:0]        lsb_off;
  logic [SLOT_W-1:0]        slot_inc;

  function automatic pins_t slot_pins(input logic [SLOT_W-1:0] s);
    pins_t p;
    p.cs  = 1'b0;
    p.clk = s[0];
    if (s < SETUP_SLOTS) begin
      p.dout = (s != SETUP_LOW_DATA);
      p.drv  = 1'b1;
    end else begin
      p.dout = 1'b1;
      p.drv  = (s <= DATA_MSB_FIRST);
    end
    return p;
  endfunction

  // a zero half period acts as one tick
  assign hp_eff   = (half_period == '0) ? HALF_PERIOD_W'(1) : half_period;
  assign tick_inc = tick_counter + HALF_PERIOD_W'(1);
  assign slot_end = (tick_inc >= hp_eff);
  assign lsb_off  = slot_index - DATA_MSB_LAST;
  assign slot_inc = slot_index + SLOT_W'(1);

  always_comb begin
    busy_next         = busy;
    slot_index_next   = slot_index;
    tick_counter_next = tick_counter;
    first_word_next   = first_word;
    second_word_next  = second_word;
    pin_levels_next   = pin_levels;
    res.done          = 1'b0;
    res.value         = '0;
    res.match         = 1'b0;

    if (!busy) begin
      if (start_req) begin
        busy_next         = 1'b1;
        slot_index_next   = '0;
        tick_counter_next = '0;
        first_word_next   = '0;
        second_word_next  = '0;
        pin_levels_next   = slot_pins('0);
      end
    end else if (!slot_end) begin
      tick_counter_next = tick_inc;
    end else begin
      tick_counter_next = '0;
      // samples land after falling edges, i.e. at the end of even slots
      if (slot_index >= DATA_MSB_FIRST && slot_index <= DATA_MSB_LAST && !slot_index[0])
        first_word_next = {first_word[WORD_W-2:0], data_in};
      if (slot_index == DATA_MSB_LAST)
        second_word_next[0] = data_in;
      if (slot_index >= DATA_LSB_FIRST && slot_index <= DATA_LSB_LAST && !slot_index[0])
        second_word_next[lsb_off[3:1]] = data_in;
      if (slot_index >= LAST_SLOT) begin
        busy_next       = 1'b0;
        slot_index_next = '0;
        pin_levels_next = PINS_FINISHED;
        res.done        = 1'b1;
        res.match       = (first_word == second_word);
        res.value       = res.match ? first_word : '0;
      end else begin
        slot_index_next = slot_inc;
        pin_levels_next = slot_pins(slot_inc);
      end
    end
    res.pins = pin_levels_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period  <= HALF_PERIOD_RESET;
      busy         <= 1'b0;
      slot_index   <= '0;
      tick_counter <= '0;
      first_word   <= '0;
      second_word  <= '0;
      pin_levels   <= PINS_RESET;
    end else begin
      if (cfg_wr_en)
        half_period <= cfg_wr_data;
      if (step) begin
        busy         <= busy_next;
        slot_index   <= slot_index_next;
        tick_counter <= tick_counter_next;
        first_word   <= first_word_next;
        second_word  <= second_word_next;
        pin_levels   <= pin_levels_next;
      end
    end
  end

endmodule

@@ hw/rtl/sars_out_reg.sv @@
// Result register between the sequencer and the output stream; holds one
// item and frees itself as it is taken. Depends on sars_pkg.
module sars_out_reg
  import sars_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  res_t                   in_res,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data
);

  res_t held;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready)
      held <= in_res;
  end

  assign out_data = {2'b00, held.match, held.value, held.done,
                     held.pins.drv, held.pins.dout, held.pins.clk, held.pins.cs};

endmodule

@@ hw/rtl/serial_adc_read_sequencer_core.sv @@
// Top level of the serial converter read sequencer.
// Depends on sars_pkg, sars_seq and sars_out_reg.
//
// Each input item is one tick of the pin sequencer; the block takes one item
// per clock cycle and returns exactly one result item for it, registered in
// the result register. Throughput is one item per cycle whenever the
// output side takes results; s_axis_tready follows m_axis_tready when the
// result register is full. A start request while idle lowers chip select and
// runs 39 slots of half_period_ticks items each (0 acts as 1); done_res is set
// on the item that ends the read, with value 0 when the two words differ.
module serial_adc_read_sequencer_core
  import sars_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [HALF_PERIOD_W-1:0] cfg_wr_data,   // half_period_ticks
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_TDATA_W-1:0]    s_axis_tdata,  // [0] start_req, [1] data_in, [7:2] zero
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [0] chip_select, [1] serial_clock, [2] data_out, [3] data_drive,
  // [4] done_res, [12:5] value, [13] words_match, [15:14] zero
  output logic [OUT_TDATA_W-1:0]   m_axis_tdata
);

  res_t res;
  logic step;

  assign step = s_axis_tvalid && s_axis_tready;

  sars_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .start_req   (s_axis_tdata[0]),
    .data_in     (s_axis_tdata[1]),
    .res         (res)
  );

  sars_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_res    (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

@@ hw/rtl/sars_chk.sv @@
// Port-level checks for serial_adc_read_sequencer_core, bound to the top.
// Depends on sars_pkg.
module sars_chk
  import sars_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // output holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result register not empty after reset");

  // finishing item shows chip select high, clock low, line driven high
  a_done_pins: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[4] |->
      m_axis_tdata[0] && !m_axis_tdata[1] && m_axis_tdata[2] && m_axis_tdata[3])
    else $error("bad pin levels on finishing item");

  a_match_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[13] |-> m_axis_tdata[4])
    else $error("words_match without done_res");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[13] |-> m_axis_tdata[12:5] == '0)
    else $error("value nonzero without a match");

endmodule

bind serial_adc_read_sequencer_core sars_chk u_sars_chk (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
